// ----- rtl/core/dptw_pkg.sv -----
`timescale 1ns / 1ps

package dptw_pkg;

    localparam int MAX_RES   = 4;
    localparam int CNT_W     = $clog2(MAX_RES + 1);
    localparam int ADDR_W    = 52;
    localparam int DATA_W    = 64;
    localparam int PAGE_W    = 36;
    localparam int IDX_W     = 9;

    // input selector codes (s_tuser)
    localparam logic [1:0] OP_FAULT = 2'd0;
    localparam logic [1:0] OP_ENTRY = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    // result kinds (m_tuser)
    localparam logic [2:0] K_READ   = 3'd0;
    localparam logic [2:0] K_WRITE  = 3'd1;
    localparam logic [2:0] K_ALLOC  = 3'd2;
    localparam logic [2:0] K_CLEAR  = 3'd3;
    localparam logic [2:0] K_INVAL  = 3'd4;
    localparam logic [2:0] K_STATUS = 3'd5;

    // walk status codes
    localparam logic [2:0] ST_MAPPED   = 3'd0;
    localparam logic [2:0] ST_RESERVED = 3'd1;
    localparam logic [2:0] ST_PROTECT  = 3'd2;
    localparam logic [2:0] ST_OOM      = 3'd3;
    localparam logic [2:0] ST_HUGE_1G  = 3'd4;
    localparam logic [2:0] ST_HUGE_2M  = 3'd5;
    localparam logic [2:0] ST_INCONS   = 3'd6;

    // table entry bits
    localparam int E_PRESENT_BIT = 0;
    localparam int E_HUGE_BIT    = 7;
    localparam logic [DATA_W-1:0] E_PRESENT  = 64'h1;
    localparam logic [DATA_W-1:0] E_WRITABLE = 64'h2;
    localparam logic [DATA_W-1:0] E_USER     = 64'h4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [2:0]        status;
    } res_t;

    // a group of results produced by one accepted word; count 0 loads nothing
    typedef struct packed {
        logic [CNT_W-1:0]       count;
        res_t [MAX_RES-1:0]     res;
    } res_load_t;

endpackage

// ----- rtl/core/dptw_result_buf.sv -----
`timescale 1ns / 1ps

module dptw_result_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  dptw_pkg::res_load_t load,
    output logic                load_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [119:0]        m_tdata,   // address[51:0], write_data[115:52], status[118:116]
    output logic [2:0]          m_tuser,   // kind
    output logic                m_tlast
);
    import dptw_pkg::*;

    localparam int SEL_W = $clog2(MAX_RES);

    res_t [MAX_RES-1:0] res_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SEL_W-1:0]   idx_reg;
    res_t               cur;
    logic               is_last;
    logic               pop;

    assign cur        = res_reg[idx_reg];
    assign is_last    = CNT_W'(idx_reg) == (cnt_reg - CNT_W'(1));
    assign m_tvalid   = cnt_reg != '0;
    assign pop        = m_tvalid && m_tready;
    assign load_ready = !m_tvalid || (pop && is_last);

    assign m_tdata = {1'b0, cur.status, cur.write_data, cur.address};
    assign m_tuser = cur.kind;
    assign m_tlast = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load.count != '0)
        begin
            cnt_reg <= load.count;
            idx_reg <= '0;
        end
        else if (pop && is_last)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (pop)
        begin
            idx_reg <= idx_reg + SEL_W'(1);
        end
    end

    // payload only; no reset
    always_ff @(posedge clk)
    begin
        if (load.count != '0)
        begin
            res_reg <= load.res;
        end
    end

endmodule

// ----- rtl/core/demand_paging_table_walker.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser opcode; tdata fault, flags, entry, frame
// m_*       out  m_tvalid/m_tready  tuser kind; tdata address, data, status; tlast
// cfg_*     in   cfg_wr_en          root table frame
//
// Each accepted word is decoded against the walk state combinationally and its
// results (one to four) land in a result buffer that drains one word a cycle
// while m_tready is high. A word with one result is taken every cycle while the
// sink keeps up; one with N results holds off the next input while the buffer drains.
// s_tready stays high through the cycle in which the last buffered word leaves.
// Reset clears the walk state, the root frame and the buffer; nothing else.
module demand_paging_table_walker
#(
    parameter int LEVELS     = 4,
    parameter int FRAME_BITS = 40
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // fault_address[47:0], err_present[48], err_write[49], err_user[50],
    // err_reserved[51], entry_data[115:52], alloc_frame[155:116]
    input  logic [159:0] s_tdata,
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // address[51:0], write_data[115:52], status[118:116]
    output logic [2:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [39:0]  cfg_wr_data
);
    import dptw_pkg::*;

    // wide enough to hold the 1G level depth even for short walks
    localparam int LVL_W = (LEVELS > 2) ? $clog2(LEVELS) : 2;
    localparam logic [LVL_W-1:0] TOP_DEPTH = LVL_W'(LEVELS - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_ALLOC
    } phase_t;

    phase_t                 phase_reg,          phase_next;
    logic [LVL_W-1:0]       walk_level_reg,     walk_level_next;
    logic [PAGE_W-1:0]      fault_page_reg,     fault_page_next;
    logic                   fault_is_write_reg, fault_is_write_next;
    logic                   fault_is_user_reg,  fault_is_user_next;
    logic [FRAME_BITS-1:0]  table_frame_reg,    table_frame_next;
    logic [39:0]            root_reg,           root_next;

    res_load_t              load;
    logic                   load_ready;
    logic                   in_acc;

    logic [47:0]            in_fault_addr;
    logic                   in_err_present;
    logic                   in_err_write;
    logic                   in_err_user;
    logic                   in_err_reserved;
    logic [DATA_W-1:0]      in_entry;
    logic [FRAME_BITS-1:0]  in_frame;

    logic [LVL_W-1:0]       depth;
    logic                   e_present;
    logic                   e_huge;
    logic [ADDR_W-1:0]      new_frame_addr;
    logic [DATA_W-1:0]      user_flag;
    logic [DATA_W-1:0]      write_flag;

    assign in_fault_addr   = s_tdata[47:0];
    assign in_err_present  = s_tdata[48];
    assign in_err_write    = s_tdata[49];
    assign in_err_user     = s_tdata[50];
    assign in_err_reserved = s_tdata[51];
    assign in_entry        = s_tdata[115:52];
    assign in_frame        = s_tdata[116 +: FRAME_BITS];

    assign s_tready = load_ready;
    assign in_acc   = s_tvalid && s_tready;

    // distance of the current level from the leaf table
    assign depth          = TOP_DEPTH - walk_level_reg;
    assign e_present      = in_entry[E_PRESENT_BIT];
    assign e_huge         = in_entry[E_HUGE_BIT];
    assign new_frame_addr = ADDR_W'({in_frame, 12'h000});
    assign user_flag      = fault_is_user_reg ? E_USER : '0;
    assign write_flag     = fault_is_write_reg ? E_WRITABLE : '0;

    // byte address of the entry for this page within the table at frame
    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [FRAME_BITS-1:0] frame,
        input logic [LVL_W-1:0]      lvl_depth,
        input logic [PAGE_W-1:0]     page
    );
        logic [PAGE_W+IDX_W-1:0] ext;
        logic [PAGE_W+IDX_W-1:0] sh;
        ext = {{IDX_W{1'b0}}, page};
        sh  = ext >> (IDX_W * int'(lvl_depth));
        return ADDR_W'({frame, sh[IDX_W-1:0], 3'b000});
    endfunction

    always_comb
    begin
        phase_next          = phase_reg;
        walk_level_next     = walk_level_reg;
        fault_page_next     = fault_page_reg;
        fault_is_write_next = fault_is_write_reg;
        fault_is_user_next  = fault_is_user_reg;
        table_frame_next    = table_frame_reg;
        root_next           = cfg_wr_en ? cfg_wr_data : root_reg;
        load                = '0;

        if (in_acc && s_tuser == OP_FAULT && phase_reg == PH_IDLE)
        begin
            fault_page_next     = in_fault_addr[47:12];
            fault_is_write_next = in_err_write;
            fault_is_user_next  = in_err_user;
            load.count          = CNT_W'(1);
            if (in_err_reserved)
            begin
                load.res[0].kind   = K_STATUS;
                load.res[0].status = ST_RESERVED;
            end
            else if (in_err_present)
            begin
                load.res[0].kind   = K_STATUS;
                load.res[0].status = ST_PROTECT;
            end
            else
            begin
                walk_level_next       = '0;
                table_frame_next      = root_reg[FRAME_BITS-1:0];
                load.res[0].kind      = K_READ;
                load.res[0].address   = entry_addr(root_reg[FRAME_BITS-1:0], TOP_DEPTH,
                                                   in_fault_addr[47:12]);
                phase_next            = PH_READ;
            end
        end
        else if (in_acc && s_tuser == OP_ENTRY && phase_reg == PH_READ)
        begin
            load.count = CNT_W'(1);
            if (e_present && e_huge && (depth == LVL_W'(1) || depth == LVL_W'(2)))
            begin
                load.res[0].kind   = K_STATUS;
                load.res[0].status = (depth == LVL_W'(2)) ? ST_HUGE_1G : ST_HUGE_2M;
                phase_next         = PH_IDLE;
            end
            else if (e_present && depth == '0)
            begin
                load.res[0].kind   = K_STATUS;
                load.res[0].status = ST_INCONS;
                phase_next         = PH_IDLE;
            end
            else if (e_present)
            begin
                table_frame_next    = in_entry[12 +: FRAME_BITS];
                walk_level_next     = walk_level_reg + LVL_W'(1);
                load.res[0].kind    = K_READ;
                load.res[0].address = entry_addr(in_entry[12 +: FRAME_BITS],
                                                 depth - LVL_W'(1), fault_page_reg);
            end
            else
            begin
                load.res[0].kind = K_ALLOC;
                phase_next       = PH_ALLOC;
            end
        end
        else if (in_acc && s_tuser == OP_ALLOC && phase_reg == PH_ALLOC)
        begin
            if (in_frame == '0)
            begin
                load.count         = CNT_W'(1);
                load.res[0].kind   = K_STATUS;
                load.res[0].status = ST_OOM;
                phase_next         = PH_IDLE;
            end
            else
            begin
                load.res[0].kind    = K_CLEAR;
                load.res[0].address = new_frame_addr;
                load.res[1].kind    = K_WRITE;
                load.res[1].address = entry_addr(table_frame_reg, depth, fault_page_reg);
                if (depth == '0)
                begin
                    // leaf: map the page, flush its translation, report
                    load.count             = CNT_W'(4);
                    load.res[1].write_data = DATA_W'(new_frame_addr) | E_PRESENT
                                             | user_flag | write_flag;
                    load.res[2].kind       = K_INVAL;
                    load.res[2].address    = ADDR_W'({fault_page_reg, 12'h000});
                    load.res[3].kind       = K_STATUS;
                    load.res[3].status     = ST_MAPPED;
                    phase_next             = PH_IDLE;
                end
                else
                begin
                    // link the new table and continue in it
                    load.count             = CNT_W'(3);
                    load.res[1].write_data = DATA_W'(new_frame_addr) | E_PRESENT
                                             | E_WRITABLE | user_flag;
                    load.res[2].kind       = K_READ;
                    load.res[2].address    = entry_addr(in_frame, depth - LVL_W'(1),
                                                        fault_page_reg);
                    table_frame_next       = in_frame;
                    walk_level_next        = walk_level_reg + LVL_W'(1);
                    phase_next             = PH_READ;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            walk_level_reg     <= '0;
            fault_page_reg     <= '0;
            fault_is_write_reg <= 1'b0;
            fault_is_user_reg  <= 1'b0;
            table_frame_reg    <= '0;
            root_reg           <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            walk_level_reg     <= walk_level_next;
            fault_page_reg     <= fault_page_next;
            fault_is_write_reg <= fault_is_write_next;
            fault_is_user_reg  <= fault_is_user_next;
            table_frame_reg    <= table_frame_next;
            root_reg           <= root_next;
        end
    end

    dptw_result_buf u_result_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == K_STATUS) |-> m_tlast)
        else $error("status word not marked last");

    a_alloc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == K_ALLOC) |-> (phase_reg == PH_ALLOC))
        else $error("allocate request shown outside allocate phase");

    a_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == K_READ) |-> (phase_reg == PH_READ))
        else $error("entry read shown outside read phase");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (walk_level_reg <= TOP_DEPTH))
        else $error("walk level beyond leaf");
`endif

endmodule

// ----- tb/sv/dptw_walk_checker.sv -----
`timescale 1ns / 1ps

module dptw_walk_checker
    import dptw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [39:0]  cfg_wr_data,
    output int           errors,
    output int           outstanding,
    output int           words_in,
    output int           words_out,
    output logic [6:0]   status_seen
);

    localparam int LEVELS     = 4;

    typedef enum logic [1:0] {WALK_IDLE, WALK_READ, WALK_ALLOC} walk_phase_e;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [2:0]        status;
        logic              last;
    } walk_word_t;

    walk_phase_e       phase;
    logic [1:0]        level;
    logic [PAGE_W-1:0] page;
    logic              is_write;
    logic              is_user;
    logic [39:0]       table_frame;
    logic [39:0]       root_frame;

    walk_word_t due_words[$];
    walk_word_t step_words[$];

    int         err_cnt;
    int         in_cnt;
    int         out_cnt;
    logic [6:0] endings;

    function automatic logic [ADDR_W-1:0] entry_address();
        int               depth;
        logic [IDX_W-1:0] idx;
        depth = LEVELS - 1 - level;
        idx = IDX_W'(page >> (IDX_W * depth));
        return {table_frame, 12'b0} + {idx, 3'b000};
    endfunction

    function automatic void add_word(input logic [2:0] kind, input logic [ADDR_W-1:0] address,
                                     input logic [DATA_W-1:0] data, input logic [2:0] st);
        step_words.push_back('{kind, address, data, st, 1'b0});
    endfunction

    // Work out every word one accepted input causes and queue them in order.
    task automatic predict_walk(input logic [1:0] op, input logic [159:0] d);
        logic [63:0]       entry;
        logic [39:0]       frame;
        logic [ADDR_W-1:0] frame_addr;
        logic [DATA_W-1:0] user_bit;
        int                depth;
        entry = d[115:52];
        frame = d[155:116];
        depth = LEVELS - 1 - level;
        step_words.delete();
        if (op == OP_FAULT && phase == WALK_IDLE)
        begin
            page = d[47:12];
            is_write = d[49];
            is_user = d[50];
            if (d[51])
                add_word(K_STATUS, '0, '0, ST_RESERVED);
            else if (d[48])
                add_word(K_STATUS, '0, '0, ST_PROTECT);
            else
            begin
                level = '0;
                table_frame = root_frame;
                add_word(K_READ, entry_address(), '0, '0);
                phase = WALK_READ;
            end
        end
        else if (op == OP_ENTRY && phase == WALK_READ)
        begin
            if (entry[0] && entry[7] && (depth == 1 || depth == 2))
            begin
                add_word(K_STATUS, '0, '0, (depth == 2) ? ST_HUGE_1G : ST_HUGE_2M);
                phase = WALK_IDLE;
            end
            else if (entry[0] && depth == 0)
            begin
                add_word(K_STATUS, '0, '0, ST_INCONS);
                phase = WALK_IDLE;
            end
            else if (entry[0])
            begin
                table_frame = entry[51:12];
                level = level + 1'b1;
                add_word(K_READ, entry_address(), '0, '0);
            end
            else
            begin
                add_word(K_ALLOC, '0, '0, '0);
                phase = WALK_ALLOC;
            end
        end
        else if (op == OP_ALLOC && phase == WALK_ALLOC)
        begin
            if (frame == '0)
            begin
                add_word(K_STATUS, '0, '0, ST_OOM);
                phase = WALK_IDLE;
            end
            else
            begin
                frame_addr = {frame, 12'b0};
                user_bit = is_user ? E_USER : '0;
                add_word(K_CLEAR, frame_addr, '0, '0);
                if (depth == 0)
                begin
                    add_word(K_WRITE, entry_address(),
                             frame_addr | E_PRESENT | user_bit | (is_write ? E_WRITABLE : '0),
                             '0);
                    add_word(K_INVAL, ADDR_W'({page, 12'b0}), '0, '0);
                    add_word(K_STATUS, '0, '0, ST_MAPPED);
                    phase = WALK_IDLE;
                end
                else
                begin
                    // link the fresh table in, then read from it like any other
                    add_word(K_WRITE, entry_address(), frame_addr | E_PRESENT | E_WRITABLE | user_bit,
                             '0);
                    table_frame = frame;
                    level = level + 1'b1;
                    add_word(K_READ, entry_address(), '0, '0);
                    phase = WALK_READ;
                end
            end
        end
        if (step_words.size() > 0)
        begin
            step_words[$].last = 1'b1;
            foreach (step_words[i])
                due_words.push_back(step_words[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            err_cnt++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        walk_word_t want;
        if (!rst_n)
        begin
            phase = WALK_IDLE;
            level = '0;
            page = '0;
            is_write = 1'b0;
            is_user = 1'b0;
            table_frame = '0;
            root_frame = '0;
            due_words.delete();
            err_cnt = 0;
            in_cnt = 0;
            out_cnt = 0;
            endings = '0;
        end
        else
        begin
            if (cfg_wr_en)
                root_frame = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                in_cnt++;
                predict_walk(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                out_cnt++;
                if (due_words.size() == 0)
                begin
                    err_cnt++;
                    $error("result word with none expected: kind %0d address %0h",
                           m_tuser, m_tdata[51:0]);
                end
                else
                begin
                    want = due_words.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("address", want.address, m_tdata[51:0]);
                    check_field("write_data", want.write_data, m_tdata[115:52]);
                    check_field("status", want.status, m_tdata[118:116]);
                    check_field("last", want.last, m_tlast);
                    if (want.kind == K_STATUS && want.status == m_tdata[118:116])
                        endings[want.status] = 1'b1;
                end
            end
        end
        errors <= err_cnt;
        outstanding <= due_words.size();
        words_in <= in_cnt;
        words_out <= out_cnt;
        status_seen <= endings;
    end

endmodule

// ----- tb/sv/tb_demand_paging_table_walker.sv -----
`timescale 1ns / 1ps

module tb_demand_paging_table_walker;
    import dptw_pkg::*;

    localparam int LEVELS          = 4;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 1000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {GEN_IDLE, GEN_READ, GEN_ALLOC} gen_phase_e;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // fault_address[47:0], err_present[48], err_write[49], err_user[50],
    // err_reserved[51], entry_data[115:52], alloc_frame[155:116]
    logic [159:0] s_tdata;
    logic [1:0]   s_tuser;      // opcode
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;      // address[51:0], write_data[115:52], status[118:116]
    logic [2:0]   m_tuser;      // kind
    logic         m_tlast;
    logic         cfg_wr_en;
    logic [39:0]  cfg_wr_data;

    int           fail_count;
    int           words_expected;
    int           words_in;
    int           words_out;
    logic [6:0]   status_seen;

    gen_phase_e   gen_phase = GEN_IDLE;
    int           gen_level = 0;
    bit           src_idle = 1'b1;
    bit           sink_idle = 1'b1;
    bit           hold_sink = 1'b0;
    int           stuck_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    demand_paging_table_walker u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    dptw_walk_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .errors      (fail_count),
        .outstanding (words_expected),
        .words_in    (words_in),
        .words_out   (words_out),
        .status_seen (status_seen)
    );

    function automatic logic [159:0] rand_payload();
        logic [159:0] r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r[159:156] = '0;
        return r;
    endfunction

    function automatic logic [47:0] rand_va();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [39:0] rand_frame();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return 40'd1;
            2: return '0;
            default: return 40'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [63:0] make_entry(input logic present, input logic huge,
                                               input logic [39:0] frame);
        logic [63:0] e;
        e = {$urandom, $urandom};
        e[0] = present;
        e[7] = huge;
        e[51:12] = frame;
        return e;
    endfunction

    task automatic write_root(input logic [39:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one word, after a random gap if src_idle, and hold it until it is taken.
    task automatic send_word(input logic [1:0] op, input logic [159:0] data);
        int gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_fault(input logic [47:0] va, input logic present, input logic wr,
                              input logic user, input logic reserved);
        logic [159:0] d;
        d = rand_payload();
        d[47:0] = va;
        d[48] = present;
        d[49] = wr;
        d[50] = user;
        d[51] = reserved;
        send_word(OP_FAULT, d);
    endtask

    task automatic send_entry(input logic [63:0] e);
        logic [159:0] d;
        d = rand_payload();
        d[115:52] = e;
        send_word(OP_ENTRY, d);
    endtask

    task automatic send_alloc(input logic [39:0] frame);
        logic [159:0] d;
        d = rand_payload();
        d[155:116] = frame;
        send_word(OP_ALLOC, d);
    endtask

    // Mostly well-formed walk traffic; the rest are words the walk is not waiting for.
    task automatic random_item(output bit useful);
        int          roll;
        int          depth;
        logic [1:0]  op;
        logic [39:0] frame;
        roll = $urandom_range(0, 99);
        depth = LEVELS - 1 - gen_level;
        useful = 1'b1;
        if (roll < 12)
        begin
            useful = 1'b0;
            case ($urandom_range(0, 2))
                0: op = (gen_phase == GEN_IDLE) ? OP_ENTRY : OP_FAULT;
                1: op = (gen_phase == GEN_ALLOC) ? OP_ENTRY : OP_ALLOC;
                default: op = OP_UNUSED;
            endcase
            send_word(op, rand_payload());
        end
        else
        begin
            roll = $urandom_range(0, 99);
            case (gen_phase)
                GEN_IDLE:
                begin
                    send_fault(rand_va(), (roll < 4) || (roll >= 8 && roll < 16),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), roll < 8);
                    if (roll >= 16)
                    begin
                        gen_phase = GEN_READ;
                        gen_level = 0;
                    end
                end
                GEN_READ:
                begin
                    if (roll < 35)
                    begin
                        send_entry(make_entry(1'b0, 1'($urandom_range(0, 1)), rand_frame()));
                        gen_phase = GEN_ALLOC;
                    end
                    else if (depth == 0)
                    begin
                        send_entry(make_entry(1'b1, 1'($urandom_range(0, 1)), rand_frame()));
                        gen_phase = GEN_IDLE;
                    end
                    else if (depth != LEVELS - 1 && roll < 45)
                    begin
                        send_entry(make_entry(1'b1, 1'b1, rand_frame()));
                        gen_phase = GEN_IDLE;
                    end
                    else
                    begin
                        // size bit only counts at the 1G and 2M levels
                        send_entry(make_entry(1'b1,
                                   (depth == LEVELS - 1) ? 1'($urandom_range(0, 1)) : 1'b0,
                                   rand_frame()));
                        gen_level++;
                    end
                end
                default:
                begin
                    frame = rand_frame();
                    if (roll < 8)
                        frame = '0;
                    else if (frame == '0)
                        frame = 40'd1;
                    send_alloc(frame);
                    if (frame == '0 || depth == 0)
                        gen_phase = GEN_IDLE;
                    else
                    begin
                        gen_phase = GEN_READ;
                        gen_level++;
                    end
                end
            endcase
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_expected != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            stall = sink_idle ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [39:0] root;
        int          count;
        bit          useful;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_FAULT;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_root('1);
        // reserved wins over present, then a plain protection fault
        send_fault('1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_fault('0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_word(OP_UNUSED, rand_payload());
        send_entry(make_entry(1'b1, 1'b1, '1));
        // walk ending in a 2M page, with stray words along the way
        send_fault('1, 1'b0, 1'b1, 1'b1, 1'b0);
        send_fault(rand_va(), 1'b0, 1'b0, 1'b0, 1'b0);
        send_entry(make_entry(1'b1, 1'b1, '1));
        send_entry(make_entry(1'b0, 1'b1, rand_frame()));
        send_entry(make_entry(1'b1, 1'b0, rand_frame()));
        send_alloc('1);
        send_entry(make_entry(1'b1, 1'b1, rand_frame()));
        // allocator out of memory
        send_fault('0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_entry(make_entry(1'b0, 1'b0, '0));
        send_alloc('0);
        // 1G page
        send_fault(rand_va(), 1'b0, 1'b1, 1'b0, 1'b0);
        send_entry(make_entry(1'b1, 1'b0, 40'd1));
        send_entry(make_entry(1'b1, 1'b1, rand_frame()));
        // missing leaf gets mapped
        send_fault(rand_va(), 1'b0, 1'b0, 1'b1, 1'b0);
        repeat (3) send_entry(make_entry(1'b1, 1'b0, rand_frame()));
        send_entry(make_entry(1'b0, 1'b1, rand_frame()));
        send_alloc(40'd1);
        // present leaf is inconsistent
        send_fault(rand_va(), 1'b0, 1'b1, 1'b1, 1'b0);
        repeat (3) send_entry(make_entry(1'b1, 1'b0, rand_frame()));
        send_entry(make_entry(1'b1, 1'b1, rand_frame()));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: root = '0;
                2: root = '1;
                3: root = 40'd1;
                default: root = 40'({$urandom, $urandom});
            endcase
            write_root(root);
            src_idle = (p != 1) && (p != 3);
            sink_idle = (p != 1) && (p != 2);
            if (p == 2)
                hold_sink = 1'b1;
            count = 0;
            while (count < ITEMS_PER_PHASE || gen_phase != GEN_IDLE)
            begin
                random_item(useful);
                if (useful)
                    count++;
            end
            drain();
        end

        $display("Walker run: %0d words offered, %0d result words checked, %0d root frames.",
                 words_in, words_out, PHASES + 1);
        $display("Walk endings seen (status codes 6 down to 0): %b", status_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
